>>> src/hjdd_pkg.sv
// Shared types and codes for the headset jack detect and hook debounce block.
`timescale 1ns / 1ps
package hjdd_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int TICKS_WIDTH     = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOOK_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLUG_LEVEL    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DETECT_TICKS  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUTTON_TICKS  = 2'd3;

    localparam logic [1:0] JACK_NONE        = 2'd0;
    localparam logic [1:0] JACK_WITH_MIC    = 2'd1;
    localparam logic [1:0] JACK_WITHOUT_MIC = 2'd2;

    localparam logic [1:0] KEY_NONE    = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_RELEASE = 2'd2;

    localparam logic [TICKS_WIDTH-1:0] DETECT_TICKS_RESET = 16'd500;
    localparam logic [TICKS_WIDTH-1:0] BUTTON_TICKS_RESET = 16'd80;

    typedef struct packed {
        logic                   hook_enable;
        logic                   plug_level;
        logic [TICKS_WIDTH-1:0] detect_ticks;
        logic [TICKS_WIDTH-1:0] button_ticks;
    } hjdd_cfg_t;

    typedef struct packed {
        logic [1:0] jack_state;
        logic       key_held;
        logic       ignore_button;
        logic       button_watch_on;
        logic       bias_on;
        logic       detect_running;
        logic       button_running;
        logic       last_detect;
        logic       last_button;
        logic       first_tick_done;
    } hjdd_flags_t;

    localparam hjdd_flags_t FLAGS_RESET = '{
        jack_state:      JACK_NONE,
        key_held:        1'b0,
        ignore_button:   1'b0,
        button_watch_on: 1'b0,
        bias_on:         1'b0,
        detect_running:  1'b0,
        button_running:  1'b0,
        last_detect:     1'b1,
        last_button:     1'b1,
        first_tick_done: 1'b0
    };

endpackage

>>> src/hjdd_if.sv
// Valid/ready channel interfaces for pin samples and jack status results.
`timescale 1ns / 1ps
interface hjdd_in_if;
    logic valid;
    logic ready;
    logic detect_pin;
    logic button_pin;

    modport source (output valid, output detect_pin, output button_pin, input ready);
    modport sink (input valid, input detect_pin, input button_pin, output ready);
endinterface

interface hjdd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] jack_state;
    logic [1:0] key_event;
    logic       mic_bias_on;

    modport source (output valid, output jack_state, output key_event, output mic_bias_on,
                    input ready);
    modport sink (input valid, input jack_state, input key_event, input mic_bias_on,
                  output ready);
endinterface

>>> src/headset_jack_detect_debounce_top.sv
// Top level of the headset jack detect and hook button debounce block.
//
// in_ch carries one tick per transfer: the sampled detect_pin and button_pin.
// Each accepted tick updates the jack state, the debounce timers and the key
// state, and yields exactly one result on out_ch: jack_state, key_event and
// mic_bias_on as they stand after that tick.
// The result is registered, valid in the cycle after the input transfer; one
// tick is taken every cycle unless the receiver stalls. The whole tick update
// is one pass through hjdd_step between the state and result registers.
// The result register doubles as the output stage: in_ch.ready is high while
// it is empty or being taken, so a stalled receiver holds its result and
// back-pressures the input without losing or repeating a tick.
// Reset clears all state, loads the register defaults (hook off, plug level 0,
// 500 detect ticks, 80 button ticks) and empties the output. The first tick
// after reset runs an initial detection when hook_enable is set. The user must
// write registers via cfg_we/cfg_index/cfg_data only while idle (unchecked).
`timescale 1ns / 1ps
module headset_jack_detect_debounce_top
    import hjdd_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    hjdd_in_if.sink                    in_ch,
    hjdd_out_if.source                 out_ch
);

    hjdd_cfg_t              cfg_reg;
    hjdd_flags_t            flags_reg;
    hjdd_flags_t            flags_next;
    logic [TIMER_WIDTH-1:0] detect_timer_reg;
    logic [TIMER_WIDTH-1:0] detect_timer_next;
    logic [TIMER_WIDTH-1:0] button_timer_reg;
    logic [TIMER_WIDTH-1:0] button_timer_next;
    logic [1:0]             key_event_next;
    logic                   out_valid_reg;
    logic [1:0]             jack_state_reg;
    logic [1:0]             key_event_reg;
    logic                   mic_bias_reg;
    logic                   in_xfer;

    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign in_xfer     = in_ch.valid & in_ch.ready;

    hjdd_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .cfg               (cfg_reg),
        .flags             (flags_reg),
        .detect_timer      (detect_timer_reg),
        .button_timer      (button_timer_reg),
        .detect_pin        (in_ch.detect_pin),
        .button_pin        (in_ch.button_pin),
        .flags_next        (flags_next),
        .detect_timer_next (detect_timer_next),
        .button_timer_next (button_timer_next),
        .key_event         (key_event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hook_enable  <= 1'b0;
            cfg_reg.plug_level   <= 1'b0;
            cfg_reg.detect_ticks <= DETECT_TICKS_RESET;
            cfg_reg.button_ticks <= BUTTON_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOOK_ENABLE:  cfg_reg.hook_enable  <= cfg_data[0];
                REG_PLUG_LEVEL:   cfg_reg.plug_level   <= cfg_data[0];
                REG_DETECT_TICKS: cfg_reg.detect_ticks <= cfg_data[TICKS_WIDTH-1:0];
                REG_BUTTON_TICKS: cfg_reg.button_ticks <= cfg_data[TICKS_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg        <= FLAGS_RESET;
            detect_timer_reg <= '0;
            button_timer_reg <= '0;
        end
        else if (in_xfer)
        begin
            flags_reg        <= flags_next;
            detect_timer_reg <= detect_timer_next;
            button_timer_reg <= button_timer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            jack_state_reg <= flags_next.jack_state;
            key_event_reg  <= key_event_next;
            mic_bias_reg   <= flags_next.bias_on;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.jack_state  = jack_state_reg;
    assign out_ch.key_event   = key_event_reg;
    assign out_ch.mic_bias_on = mic_bias_reg;

endmodule

>>> src/hjdd_step.sv
// Next-state logic for one tick: detect and button debounce, insert and remove.
`timescale 1ns / 1ps
module hjdd_step
    import hjdd_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  hjdd_cfg_t              cfg,
    input  hjdd_flags_t            flags,
    input  logic [TIMER_WIDTH-1:0] detect_timer,
    input  logic [TIMER_WIDTH-1:0] button_timer,
    input  logic                   detect_pin,
    input  logic                   button_pin,
    output hjdd_flags_t            flags_next,
    output logic [TIMER_WIDTH-1:0] detect_timer_next,
    output logic [TIMER_WIDTH-1:0] button_timer_next,
    output logic [1:0]             key_event
);

    localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF >> (32 - TIMER_WIDTH);
    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

    function automatic logic [TIMER_WIDTH-1:0] load_value(input logic [TICKS_WIDTH-1:0] ticks);
        logic [31:0] t;
        t = {{(32 - TICKS_WIDTH){1'b0}}, ticks};
        if (t > TIMER_MAX)
        begin
            t = TIMER_MAX;
        end
        if (t == 32'd0)
        begin
            t = 32'd1;
        end
        return t[TIMER_WIDTH-1:0];
    endfunction

    function automatic void detect_check(input hjdd_cfg_t c, input logic det, input logic btn,
                                         inout hjdd_flags_t f, inout logic [1:0] ev);
        if (det != c.plug_level)
        begin
            if (f.jack_state == JACK_WITH_MIC || f.jack_state == JACK_WITHOUT_MIC)
            begin
                f.jack_state = JACK_NONE;
                if (c.hook_enable)
                begin
                    f.button_watch_on = 1'b0;
                    if (f.key_held)
                    begin
                        f.key_held = 1'b0;
                        ev = KEY_RELEASE;
                    end
                    f.bias_on = 1'b0;
                end
            end
        end
        else if (f.jack_state == JACK_NONE && c.hook_enable)
        begin
            f.bias_on       = 1'b1;
            f.ignore_button = ~btn;
            if (!btn)
            begin
                f.button_watch_on = 1'b0;
                f.jack_state      = JACK_WITHOUT_MIC;
            end
            else
            begin
                f.jack_state      = JACK_WITH_MIC;
                f.button_watch_on = 1'b1;
            end
        end
    endfunction

    always_comb
    begin
        hjdd_flags_t            f;
        logic [1:0]             ev;
        logic [TIMER_WIDTH-1:0] dt;
        logic [TIMER_WIDTH-1:0] bt;

        f  = flags;
        ev = KEY_NONE;
        dt = detect_timer;
        bt = button_timer;

        if (!f.first_tick_done)
        begin
            f.first_tick_done = 1'b1;
            if (cfg.hook_enable)
            begin
                detect_check(cfg, detect_pin, button_pin, f, ev);
            end
        end

        if (detect_pin != f.last_detect)
        begin
            if ((f.jack_state == JACK_NONE) == (detect_pin == cfg.plug_level))
            begin
                if (f.jack_state == JACK_WITH_MIC)
                begin
                    f.ignore_button = 1'b1;
                end
                dt               = load_value(cfg.detect_ticks);
                f.detect_running = 1'b1;
            end
        end
        else if (f.detect_running)
        begin
            dt = dt - TIMER_ONE;
            if (dt == '0)
            begin
                f.detect_running = 1'b0;
                detect_check(cfg, detect_pin, button_pin, f, ev);
            end
        end
        f.last_detect = detect_pin;

        if (button_pin != f.last_button && f.button_watch_on)
        begin
            bt               = load_value(cfg.button_ticks);
            f.button_running = 1'b1;
        end
        else if (f.button_running)
        begin
            bt = bt - TIMER_ONE;
            if (bt == '0)
            begin
                f.button_running = 1'b0;
                if (f.jack_state == JACK_WITH_MIC)
                begin
                    if (button_pin)
                    begin
                        if (f.ignore_button)
                        begin
                            f.ignore_button = 1'b0;
                        end
                        else if (f.key_held)
                        begin
                            f.key_held = 1'b0;
                            ev         = KEY_RELEASE;
                        end
                    end
                    else if (!f.ignore_button && !f.key_held)
                    begin
                        f.key_held = 1'b1;
                        ev         = KEY_PRESS;
                    end
                end
            end
        end
        f.last_button = button_pin;

        flags_next        = f;
        detect_timer_next = dt;
        button_timer_next = bt;
        key_event         = ev;
    end

endmodule

>>> src/hjdd_checker.sv
// Port-level checks on the result channel of the jack detect block, with bind.
`timescale 1ns / 1ps
module hjdd_checker
    import hjdd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] jack_state,
    input logic [1:0] key_event
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(jack_state) && $stable(key_event))
        else $error("result changed while stalled");

    a_jack_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> jack_state == JACK_NONE || jack_state == JACK_WITH_MIC ||
                      jack_state == JACK_WITHOUT_MIC)
        else $error("jack state out of range");

    a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_event == KEY_NONE || key_event == KEY_PRESS ||
                      key_event == KEY_RELEASE)
        else $error("key event out of range");

    a_press_needs_mic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_event == KEY_PRESS |-> jack_state == JACK_WITH_MIC)
        else $error("hook press without a headset with mic");

endmodule

bind headset_jack_detect_debounce_top hjdd_checker u_hjdd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .jack_state (out_ch.jack_state),
    .key_event  (out_ch.key_event)
);

>>> tb/tb_top.sv
// Self-checking testbench for the headset jack detect and hook debounce block.
`timescale 1ns / 1ps
module tb_top;
    import hjdd_pkg::*;

    typedef struct packed {
        logic [1:0] jack_state;
        logic [1:0] key_event;
        logic       mic_bias_on;
    } jack_status_t;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

    typedef struct {
        logic         cfg_row;
        logic         hook;
        logic         det;
        logic         btn;
        logic         typed;
        jack_status_t want;
    } plug_row_t;

    typedef struct {
        logic        hook;
        logic        plug;
        logic [15:0] det_ticks;
        logic [15:0] btn_ticks;
        flow_t       flow;
        int unsigned ticks;
    } phase_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    hjdd_in_if  tick_ch();
    hjdd_out_if status_ch();

    headset_jack_detect_debounce_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (tick_ch),
        .out_ch    (status_ch)
    );

    // jack model state and register copies
    logic        set_hook;
    logic        set_plug;
    logic [15:0] set_det_ticks;
    logic [15:0] set_btn_ticks;
    logic [1:0]  jk_jack;
    logic        jk_key_held;
    logic        jk_ignore;
    logic        jk_watch;
    logic        jk_bias;
    logic [15:0] jk_det_timer;
    logic        jk_det_run;
    logic [15:0] jk_btn_timer;
    logic        jk_btn_run;
    logic        jk_last_det;
    logic        jk_last_btn;
    logic        jk_first_done;
    logic [1:0]  jk_key_ev;

    jack_status_t status_due[$];
    int unsigned  errors;
    flow_t        flow;
    plug_row_t    plug_rows[27];
    phase_t       phases[9];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [15:0] debounce_load(input logic [15:0] ticks);
        return (ticks == 16'd0) ? 16'd1 : ticks;
    endfunction

    function automatic void detection_check(input logic det, input logic btn);
        if (det != set_plug)
        begin
            if (jk_jack != JACK_NONE)
            begin
                jk_jack = JACK_NONE;
                if (set_hook)
                begin
                    jk_watch = 1'b0;
                    if (jk_key_held)
                    begin
                        jk_key_held = 1'b0;
                        jk_key_ev   = KEY_RELEASE;
                    end
                    jk_bias = 1'b0;
                end
            end
        end
        else if (jk_jack == JACK_NONE && set_hook)
        begin
            jk_bias   = 1'b1;
            jk_ignore = ~btn;
            jk_watch  = btn;
            jk_jack   = btn ? JACK_WITH_MIC : JACK_WITHOUT_MIC;
        end
    endfunction

    function automatic jack_status_t advance_jack_tick(input logic det, input logic btn);
        jack_status_t st;
        jk_key_ev = KEY_NONE;
        if (!jk_first_done)
        begin
            jk_first_done = 1'b1;
            if (set_hook)
                detection_check(det, btn);
        end
        if (det != jk_last_det)
        begin
            if ((jk_jack == JACK_NONE) == (det == set_plug))
            begin
                if (jk_jack == JACK_WITH_MIC)
                    jk_ignore = 1'b1;
                jk_det_timer = debounce_load(set_det_ticks);
                jk_det_run   = 1'b1;
            end
        end
        else if (jk_det_run)
        begin
            jk_det_timer = jk_det_timer - 16'd1;
            if (jk_det_timer == 16'd0)
            begin
                jk_det_run = 1'b0;
                detection_check(det, btn);
            end
        end
        jk_last_det = det;
        if (btn != jk_last_btn && jk_watch)
        begin
            jk_btn_timer = debounce_load(set_btn_ticks);
            jk_btn_run   = 1'b1;
        end
        else if (jk_btn_run)
        begin
            jk_btn_timer = jk_btn_timer - 16'd1;
            if (jk_btn_timer == 16'd0)
            begin
                jk_btn_run = 1'b0;
                if (jk_jack == JACK_WITH_MIC)
                begin
                    if (btn)
                    begin
                        if (jk_ignore)
                            jk_ignore = 1'b0;
                        else if (jk_key_held)
                        begin
                            jk_key_held = 1'b0;
                            jk_key_ev   = KEY_RELEASE;
                        end
                    end
                    else if (!jk_ignore && !jk_key_held)
                    begin
                        jk_key_held = 1'b1;
                        jk_key_ev   = KEY_PRESS;
                    end
                end
            end
        end
        jk_last_btn = btn;
        st.jack_state  = jk_jack;
        st.key_event   = jk_key_ev;
        st.mic_bias_on = jk_bias;
        return st;
    endfunction

    function automatic int unsigned run_length(input logic [15:0] ticks);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(1, 2);
        if (ticks > 16'd30)
            return $urandom_range(1, 40);
        return ticks + $urandom_range(1, 6);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic write_settings(input logic hook, input logic plug,
                                  input logic [15:0] det_t, input logic [15:0] btn_t);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HOOK_ENABLE;
        cfg_data  <= {15'($urandom), hook};
        @(posedge clk);
        cfg_index <= REG_PLUG_LEVEL;
        cfg_data  <= {15'($urandom), plug};
        @(posedge clk);
        cfg_index <= REG_DETECT_TICKS;
        cfg_data  <= det_t;
        @(posedge clk);
        cfg_index <= REG_BUTTON_TICKS;
        cfg_data  <= btn_t;
        @(posedge clk);
        cfg_we        <= 1'b0;
        set_hook      = hook;
        set_plug      = plug;
        set_det_ticks = det_t;
        set_btn_ticks = btn_t;
    endtask

    task automatic send_tick(input logic det, input logic btn, input logic typed,
                             input jack_status_t want);
        jack_status_t st;
        int unsigned  pct;
        pct = (flow == FLOW_SRC_IDLE) ? 66 : (flow == FLOW_BOTH) ? 20 : 0;
        while ($urandom_range(0, 99) < pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.detect_pin <= det;
        tick_ch.button_pin <= btn;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        st = advance_jack_tick(det, btn);
        status_due.push_back(typed ? want : st);
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        tick_ch.valid <= 1'b0;
        while (status_due.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // result side: random stall, compare each transfer with the oldest expectation
    initial
    begin
        jack_status_t want;
        int unsigned  pct;
        status_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (status_ch.valid && status_ch.ready)
            begin
                if (status_due.size() == 0)
                    flag_error($sformatf("unexpected result jack=%0d key=%0d bias=%0d",
                                         status_ch.jack_state, status_ch.key_event,
                                         status_ch.mic_bias_on));
                else
                begin
                    want = status_due.pop_front();
                    if (status_ch.jack_state !== want.jack_state ||
                        status_ch.key_event !== want.key_event ||
                        status_ch.mic_bias_on !== want.mic_bias_on)
                        flag_error($sformatf(
                            "mismatch: exp jack=%0d key=%0d bias=%0d, got jack=%0d key=%0d bias=%0d",
                            want.jack_state, want.key_event, want.mic_bias_on,
                            status_ch.jack_state, status_ch.key_event,
                            status_ch.mic_bias_on));
                end
            end
            pct = (flow == FLOW_SINK_STALL) ? 66 : (flow == FLOW_BOTH) ? 20 : 0;
            status_ch.ready <= ($urandom_range(0, 99) >= pct);
        end
    end

    initial
    begin
        logic         det_level;
        logic         btn_level;
        int unsigned  det_left;
        int unsigned  btn_left;
        jack_status_t none_st;

        none_st            = '0;
        errors             = 0;
        flow               = FLOW_FREE;
        rst_n              = 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_HOOK_ENABLE;
        cfg_data           <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.detect_pin <= 1'b0;
        tick_ch.button_pin <= 1'b0;

        set_hook      = 1'b0;
        set_plug      = 1'b0;
        set_det_ticks = DETECT_TICKS_RESET;
        set_btn_ticks = BUTTON_TICKS_RESET;
        jk_jack       = JACK_NONE;
        jk_key_held   = 1'b0;
        jk_ignore     = 1'b0;
        jk_watch      = 1'b0;
        jk_bias       = 1'b0;
        jk_det_timer  = '0;
        jk_det_run    = 1'b0;
        jk_btn_timer  = '0;
        jk_btn_run    = 1'b0;
        jk_last_det   = 1'b1;
        jk_last_btn   = 1'b1;
        jk_first_done = 1'b0;
        jk_key_ev     = KEY_NONE;

        // hook on, plug level 0, zero debounce (acts as one tick)
        plug_rows = '{
            '{0, 0, 0, 1, 1, '{JACK_WITH_MIC, KEY_NONE, 1'b1}},    // detection on first tick
            '{0, 0, 0, 0, 0, '0},
            '{0, 0, 0, 0, 1, '{JACK_WITH_MIC, KEY_PRESS, 1'b1}},
            '{0, 0, 0, 1, 0, '0},
            '{0, 0, 0, 1, 1, '{JACK_WITH_MIC, KEY_RELEASE, 1'b1}},
            '{0, 0, 0, 0, 0, '0},
            '{0, 0, 0, 0, 0, '0},
            '{0, 0, 1, 0, 0, '0},
            '{0, 0, 1, 0, 1, '{JACK_NONE, KEY_RELEASE, 1'b0}},     // removal with key held
            '{0, 0, 0, 1, 0, '0},
            '{0, 0, 0, 0, 1, '{JACK_WITHOUT_MIC, KEY_NONE, 1'b1}},
            '{0, 0, 1, 0, 0, '0},
            '{0, 0, 1, 0, 1, '{JACK_NONE, KEY_NONE, 1'b0}},
            '{0, 0, 0, 1, 0, '0},
            '{0, 0, 1, 1, 0, '0},                                 // bounce back, timer runs on
            '{0, 0, 1, 1, 0, '0},
            '{0, 0, 0, 1, 0, '0},
            '{0, 0, 0, 1, 0, '0},
            '{0, 0, 0, 0, 0, '0},
            '{0, 0, 1, 0, 0, '0},
            '{0, 0, 1, 1, 0, '0},
            '{0, 0, 0, 1, 0, '0},
            '{0, 0, 0, 1, 0, '0},
            '{1, 0, 0, 0, 0, '0},                                 // hook off, headset present
            '{0, 0, 1, 1, 0, '0},
            '{0, 0, 1, 1, 1, '{JACK_NONE, KEY_NONE, 1'b1}},
            '{0, 0, 0, 0, 0, '0}
        };

        phases = '{
            '{1'b1, 1'b1, 16'd3,     16'd2,     FLOW_FREE,       250},
            '{1'b1, 1'b0, 16'd1,     16'd1,     FLOW_SRC_IDLE,   250},
            '{1'b0, 1'b0, 16'd2,     16'd3,     FLOW_SINK_STALL, 200},
            '{1'b1, 1'b1, 16'd65535, 16'd65535, FLOW_BOTH,       60},
            '{1'b1, 1'b0, 16'd4,     16'd6,     FLOW_BOTH,       300},
            '{1'b1, 1'b1, 16'd0,     16'd0,     FLOW_FREE,       250},
            '{1'b1, 1'b0, 16'd8,     16'd5,     FLOW_SRC_IDLE,   150},
            '{1'b0, 1'b1, 16'd1,     16'd2,     FLOW_BOTH,       120},
            '{1'b1, 1'b0, 16'd1,     16'd1,     FLOW_SINK_STALL, 80}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_settings(1'b1, 1'b0, 16'd0, 16'd0);
        foreach (plug_rows[i])
        begin
            if (plug_rows[i].cfg_row)
            begin
                drain();
                write_settings(plug_rows[i].hook, set_plug, set_det_ticks, set_btn_ticks);
            end
            else
                send_tick(plug_rows[i].det, plug_rows[i].btn, plug_rows[i].typed,
                          plug_rows[i].want);
        end

        det_level = 1'b0;
        btn_level = 1'b1;
        det_left  = 0;
        btn_left  = 0;
        foreach (phases[p])
        begin
            drain();
            flow = phases[p].flow;
            write_settings(phases[p].hook, phases[p].plug,
                           phases[p].det_ticks, phases[p].btn_ticks);
            for (int unsigned n = 0; n < phases[p].ticks; n++)
            begin
                if (det_left == 0)
                begin
                    if ($urandom_range(0, 3) != 0)
                        det_level = ~det_level;
                    det_left = run_length(set_det_ticks);
                end
                if (btn_left == 0)
                begin
                    if ($urandom_range(0, 3) != 0)
                        btn_level = ~btn_level;
                    btn_left = run_length(set_btn_ticks);
                end
                det_left--;
                btn_left--;
                send_tick(det_level, btn_level, 1'b0, none_st);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (status_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", status_due.size()));
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
